// ===== hw/rtl/lock_contention_stat_table_core_defines.svh =====
// assertion macros for the lock contention statistics table
// used by lock_contention_stat_table_core, expects clk and arst_n in scope
`ifndef LOCK_CONTENTION_STAT_TABLE_CORE_DEFINES_SVH
`define LOCK_CONTENTION_STAT_TABLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LCST_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcst assertion failed");
`define LCST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcst assertion failed");
`else
`define LCST_ASSERT_SAME(label, ante, cons)
`define LCST_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/lcst_pkg.sv =====
// types and constants for the lock contention statistics table
// no dependencies
`timescale 1ns / 1ps
package lcst_pkg;
	localparam int SLOT_COUNT  = 32;
	localparam int SLOT_BITS   = 5;
	localparam int WAITER_BITS = 16;
	localparam int DATA_BITS   = 64;
	localparam int DIV_CNT_BITS = 7;

	typedef enum logic [2:0] {
		FN_SPIN_BEGIN  = 3'd0,
		FN_SPIN_END    = 3'd1,
		FN_YIELD_BEGIN = 3'd2,
		FN_YIELD_END   = 3'd3,
		FN_READ        = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [63:0] lock_key;
		logic [63:0] waited_cycles;
		logic [4:0]  read_index;
	} evt_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  slot_used;
		logic [63:0] entry_key;
		logic        entry_is_yield;
		logic [63:0] entry_hits;
		logic [15:0] entry_waiters;
		logic [63:0] entry_wait_avg;
		logic [63:0] entry_wait_max;
		logic [63:0] overflow_total;
		logic        reportable;
	} rsp_t;

	typedef struct packed {
		logic [63:0]            hits;
		logic [WAITER_BITS-1:0] waiters;
		logic [63:0]            total;
		logic [63:0]            maxv;
	} entry_t;
endpackage

// ===== hw/rtl/lcst_if.sv =====
// valid/ready channels for events and results
// depends on lcst_pkg
`timescale 1ns / 1ps
interface lcst_evt_if;
	logic              valid;
	logic              ready;
	lcst_pkg::evt_t    data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lcst_rsp_if;
	logic              valid;
	logic              ready;
	lcst_pkg::rsp_t    data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lock_contention_stat_table_core.sv =====
// lock contention statistics table: key match in flops, counters in one ram
// depends on lcst_pkg, lcst_if and lock_contention_stat_table_core_defines.svh
//
// channel | dir | payload
// evt     | in  | func, lock_key, waited_cycles, read_index
// rsp     | out | status, slot_used, entry_*, overflow_total, reportable
//
// one item passes through lookup and ram read, update, then a
// 64-step restoring divider for the average, plus the output wait
// the counter ram needs no clearing: a slot with a zero key reads as zero counters
// a new event is taken while the previous result still waits in the output register
`timescale 1ns / 1ps
`include "lock_contention_stat_table_core_defines.svh"
module lock_contention_stat_table_core (
	input  logic        clk,
	input  logic        arst_n,
	lcst_evt_if.sink    evt,
	lcst_rsp_if.source  rsp
);
	import lcst_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_LOOK, S_MOD, S_DIV, S_DONE} state_t;

	state_t                  state_q;
	evt_t                    evt_q;
	logic [63:0]             keys_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]   kinds_q;
	entry_t                  mem [SLOT_COUNT];
	entry_t                  rd_s2;
	logic [SLOT_BITS-1:0]    slot_q;
	logic                    found_q;
	logic                    was_free_q;
	logic [63:0]             ovf_q;
	rsp_t                    res_q;
	rsp_t                    out_q;
	logic                    out_valid_q;
	logic [63:0]             rem_q;
	logic [63:0]             quo_q;
	logic [63:0]             dsr_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;

	logic [SLOT_BITS-1:0]    look_slot;
	logic                    look_found;
	logic                    is_begin, is_end, do_upd, rep;
	entry_t                  old_e, new_e;
	logic [64:0]             rem_sh;
	logic [64:0]             rem_dif;
	logic                    rem_ge;
	rsp_t                    res_d;
	rsp_t                    out_d;

	always_comb begin
		look_slot  = '0;
		look_found = 1'b0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (keys_q[i] == evt_q.lock_key || keys_q[i] == '0) begin
				look_slot  = SLOT_BITS'(i);
				look_found = 1'b1;
			end
		end
		if (evt_q.func == FN_READ) begin
			look_slot  = evt_q.read_index[SLOT_BITS-1:0];
			look_found = 32'(evt_q.read_index) < SLOT_COUNT;
		end
	end

	always_comb begin
		is_begin = evt_q.func == FN_SPIN_BEGIN || evt_q.func == FN_YIELD_BEGIN;
		is_end   = evt_q.func == FN_SPIN_END || evt_q.func == FN_YIELD_END;
		do_upd   = (is_begin || is_end) && evt_q.lock_key != '0 && found_q;
		old_e    = was_free_q ? '0 : rd_s2;
		new_e    = old_e;
		if (is_begin) begin
			new_e.waiters = old_e.waiters + 1'b1;
		end else begin
			new_e.waiters = old_e.waiters - 1'b1;
			new_e.hits    = old_e.hits + 64'd1;
			if (evt_q.func == FN_SPIN_END) begin
				new_e.total = old_e.total + evt_q.waited_cycles;
				if (evt_q.waited_cycles > old_e.maxv) new_e.maxv = evt_q.waited_cycles;
			end
		end
		if (!do_upd) new_e = old_e;
		rep = found_q && !was_free_q && (evt_q.func == FN_READ || do_upd);
		if (do_upd) rep = 1'b1;
		rem_sh  = {rem_q, quo_q[63]};
		rem_dif = rem_sh - {1'b0, dsr_q};
		rem_ge  = rem_sh >= {1'b0, dsr_q};
	end

	always_comb begin
		res_d = '0;
		res_d.overflow_total = ovf_q;
		if (evt_q.func == FN_READ) begin
			res_d.slot_used = evt_q.read_index;
		end else if (is_begin || is_end) begin
			if (evt_q.lock_key == '0) begin
				res_d.status = ST_ZERO;
			end else if (!found_q) begin
				res_d.status = ST_FULL;
				if (is_begin) res_d.overflow_total = ovf_q + 64'd1;
			end else begin
				res_d.slot_used = slot_q;
			end
		end
		if (rep) begin
			res_d.entry_key      = was_free_q ? evt_q.lock_key : keys_q[slot_q];
			res_d.entry_is_yield = was_free_q
				? (evt_q.func == FN_YIELD_BEGIN || evt_q.func == FN_YIELD_END)
				: kinds_q[slot_q];
			res_d.entry_hits     = new_e.hits;
			res_d.entry_waiters  = new_e.waiters;
			res_d.entry_wait_max = new_e.maxv;
			res_d.reportable     = new_e.hits != '0 || new_e.waiters != '0;
		end
		out_d                = res_q;
		out_d.entry_wait_avg = dsr_q == '0 ? '0 : quo_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LOOK) rd_s2 <= mem[look_slot];
		if (state_q == S_MOD && do_upd) mem[slot_q] <= new_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			ovf_q       <= '0;
			kinds_q     <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) keys_q[i] <= '0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || rsp.ready)) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (evt.valid) begin
						evt_q   <= evt.data;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					slot_q     <= look_slot;
					found_q    <= look_found;
					was_free_q <= keys_q[look_slot] == '0;
					state_q    <= S_MOD;
				end
				S_MOD: begin
					res_q <= res_d;
					if (do_upd && was_free_q) begin
						keys_q[slot_q]  <= evt_q.lock_key;
						kinds_q[slot_q] <= evt_q.func == FN_YIELD_BEGIN
							|| evt_q.func == FN_YIELD_END;
					end
					if (is_begin && evt_q.lock_key != '0 && !found_q) ovf_q <= ovf_q + 64'd1;
					rem_q   <= '0;
					quo_q   <= rep ? new_e.total : '0;
					dsr_q   <= rep ? new_e.hits : '0;
					cnt_q   <= DIV_CNT_BITS'(DATA_BITS);
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= rem_ge ? rem_dif[63:0] : rem_sh[63:0];
					quo_q <= {quo_q[62:0], rem_ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == DIV_CNT_BITS'(1)) state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_q   <= out_d;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign evt.ready = state_q == S_IDLE;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	`LCST_ASSERT_NEXT(a_look_to_mod, state_q == S_LOOK, state_q == S_MOD)
	`LCST_ASSERT_NEXT(a_div_ends, state_q == S_DIV && cnt_q == DIV_CNT_BITS'(1), state_q == S_DONE)
	`LCST_ASSERT_NEXT(a_claim_sticks, state_q == S_MOD && do_upd, keys_q[slot_q] != '0)
	`LCST_ASSERT_SAME(a_ready_idle_only, evt.ready, !(state_q == S_DIV || state_q == S_MOD))
endmodule

// ===== tb/lcst_stat_checker.sv =====
// checker for the lock contention statistics table: watches evt and rsp transfers
// predicts each result from a private copy of the table; depends on lcst_pkg, lcst_if
`timescale 1ns / 1ps
module lcst_stat_checker (
	input  logic       clk,
	input  logic       arst_n,
	lcst_evt_if.sink   evt_mon,
	lcst_rsp_if.sink   rsp_mon,
	output int         fail_count,
	output int         pending_count
);
	import lcst_pkg::*;

	logic [63:0]            t_key   [SLOT_COUNT];
	logic                   t_yield [SLOT_COUNT];
	logic [63:0]            t_hits  [SLOT_COUNT];
	logic [WAITER_BITS-1:0] t_wait  [SLOT_COUNT];
	logic [63:0]            t_total [SLOT_COUNT];
	logic [63:0]            t_max   [SLOT_COUNT];
	logic [63:0]            t_ovf;
	rsp_t                   stat_fifo [$];

	function automatic void fill_entry(int s, ref rsp_t r);
		if (t_key[s] != 0) begin
			r.entry_key      = t_key[s];
			r.entry_is_yield = t_yield[s];
			r.entry_hits     = t_hits[s];
			r.entry_waiters  = t_wait[s];
			r.entry_wait_avg = (t_hits[s] != 0) ? t_total[s] / t_hits[s] : 64'd0;
			r.entry_wait_max = t_max[s];
			r.reportable     = (t_hits[s] != 0) || (t_wait[s] != 0);
		end
	endfunction

	function automatic rsp_t apply_event(evt_t e);
		rsp_t r;
		int s;
		bit is_begin;
		r = '0;
		s = -1;
		is_begin = (e.func == FN_SPIN_BEGIN) || (e.func == FN_YIELD_BEGIN);
		if (e.func == FN_READ) begin
			r.slot_used = e.read_index;
			fill_entry(e.read_index, r);
		end else if (e.func > FN_READ) begin
		end else if (e.lock_key == 0) begin
			r.status = ST_ZERO;
		end else begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (t_key[i] == e.lock_key) begin
					s = i;
					break;
				end
				if (t_key[i] == 0) begin
					t_key[i] = e.lock_key;
					t_yield[i] = (e.func >= FN_YIELD_BEGIN);
					s = i;
					break;
				end
			end
			if (s < 0) begin
				if (is_begin)
					t_ovf = t_ovf + 1;
				r.status = ST_FULL;
			end else begin
				if (is_begin) begin
					t_wait[s] = t_wait[s] + 1'b1;
				end else begin
					t_wait[s] = t_wait[s] - 1'b1;
					t_hits[s] = t_hits[s] + 1;
					if (e.func == FN_SPIN_END) begin
						t_total[s] = t_total[s] + e.waited_cycles;
						if (e.waited_cycles > t_max[s])
							t_max[s] = e.waited_cycles;
					end
				end
				r.slot_used = s[4:0];
				fill_entry(s, r);
			end
		end
		r.overflow_total = t_ovf;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t x, a;
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				t_key[i] = 0; t_yield[i] = 0; t_hits[i] = 0;
				t_wait[i] = 0; t_total[i] = 0; t_max[i] = 0;
			end
			t_ovf = 0;
			fail_count = 0;
			stat_fifo.delete();
			pending_count = 0;
		end else begin
			if (rsp_mon.valid && rsp_mon.ready) begin
				a = rsp_mon.data;
				if (stat_fifo.size() == 0) begin
					$error("result transfer with no expectation");
					fail_count++;
				end else begin
					x = stat_fifo.pop_front();
					if (a.status != x.status) begin
						$error("status exp %0d got %0d", x.status, a.status); fail_count++; end
					if (a.slot_used != x.slot_used) begin
						$error("slot_used exp %0d got %0d", x.slot_used, a.slot_used);
						fail_count++; end
					if (a.entry_key != x.entry_key) begin
						$error("entry_key exp %h got %h", x.entry_key, a.entry_key);
						fail_count++; end
					if (a.entry_is_yield != x.entry_is_yield) begin
						$error("entry_is_yield exp %0d got %0d", x.entry_is_yield,
							a.entry_is_yield); fail_count++; end
					if (a.entry_hits != x.entry_hits) begin
						$error("entry_hits exp %0d got %0d", x.entry_hits, a.entry_hits);
						fail_count++; end
					if (a.entry_waiters != x.entry_waiters) begin
						$error("entry_waiters exp %0d got %0d", x.entry_waiters,
							a.entry_waiters); fail_count++; end
					if (a.entry_wait_avg != x.entry_wait_avg) begin
						$error("entry_wait_avg exp %0d got %0d", x.entry_wait_avg,
							a.entry_wait_avg); fail_count++; end
					if (a.entry_wait_max != x.entry_wait_max) begin
						$error("entry_wait_max exp %0d got %0d", x.entry_wait_max,
							a.entry_wait_max); fail_count++; end
					if (a.overflow_total != x.overflow_total) begin
						$error("overflow_total exp %0d got %0d", x.overflow_total,
							a.overflow_total); fail_count++; end
					if (a.reportable != x.reportable) begin
						$error("reportable exp %0d got %0d", x.reportable, a.reportable);
						fail_count++; end
				end
			end
			if (evt_mon.valid && evt_mon.ready)
				stat_fifo.push_back(apply_event(evt_mon.data));
			pending_count = stat_fifo.size();
		end
	end
endmodule

// ===== tb/tb_lock_contention_stat_table_core.sv =====
// stimulus and verdict for lock_contention_stat_table_core
// depends on lcst_pkg, lcst_if, lcst_stat_checker and the block itself
`timescale 1ns / 1ps
module tb_lock_contention_stat_table_core;
	import lcst_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count, pending_count;
	bit   no_idle = 0;
	bit   long_hold = 0;
	logic [63:0] key_pool [48];

	lcst_evt_if evt_ch();
	lcst_rsp_if rsp_ch();

	lock_contention_stat_table_core DUT (.clk(clk), .arst_n(arst_n), .evt(evt_ch), .rsp(rsp_ch));
	lcst_stat_checker chk (.clk(clk), .arst_n(arst_n), .evt_mon(evt_ch), .rsp_mon(rsp_ch),
		.fail_count(fail_count), .pending_count(pending_count));

	always #2 clk = ~clk;

	initial begin
		#8_000_000;
		$display("FAIL");
		$finish;
	end

	// receiver: random stall bursts, one long hold
	initial begin
		int n;
		rsp_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				rsp_ch.ready <= 0;
				repeat (400) @(posedge clk);
				long_hold = 0;
			end else if (!no_idle && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 7);
				rsp_ch.ready <= 0;
				repeat (n - 1) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1;
			end
		end
	end

	task automatic send_evt(logic [2:0] f, logic [63:0] k, logic [63:0] w, logic [4:0] ri);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			evt_ch.valid <= 0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		evt_ch.valid <= 1;
		evt_ch.data  <= '{func: f, lock_key: k, waited_cycles: w, read_index: ri};
		@(posedge clk);
		while (!evt_ch.ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		evt_ch.valid <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		logic [2:0] f;
		logic [63:0] k;
		evt_ch.valid = 0;
		evt_ch.data = '0;
		for (int i = 0; i < 48; i++) key_pool[i] = rnd64() | 64'd1;
		key_pool[0] = '1;
		key_pool[1] = 64'd1;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed part
		send_evt(FN_READ, 0, 0, 0);
		send_evt(FN_SPIN_BEGIN, 0, 0, 0);
		send_evt(FN_SPIN_BEGIN, '1, 0, 0);
		send_evt(FN_SPIN_END, '1, '1, 0);
		send_evt(FN_SPIN_END, '1, 64'd5, 0);
		send_evt(FN_YIELD_END, 64'd1, 0, 0);
		send_evt(FN_YIELD_BEGIN, 64'd1, 0, 0);
		send_evt(FN_SPIN_END, 64'd1, 64'd100, 0);
		send_evt(3'd5, '1, '1, 5'd31);
		send_evt(3'd7, 0, 0, 0);
		send_evt(FN_READ, 0, 0, 0);
		send_evt(FN_READ, 0, 0, 5'd1);
		send_evt(FN_READ, 0, 0, 5'd31);
		send_evt(FN_YIELD_END, 0, '1, '1);
		wait_drained();
		// long receiver hold while the sender keeps offering
		long_hold = 1;
		for (int i = 0; i < 30; i++)
			send_evt(FN_READ, 0, 0, 5'($urandom_range(0, 31)));
		wait_drained();
		// random part: mostly pooled keys, overflow once table fills
		for (int i = 0; i < 1420; i++) begin
			if (i == 1300) no_idle = 1;
			f = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
			case ($urandom_range(0, 9))
				0: k = 0;
				1: k = rnd64();
				default: k = key_pool[$urandom_range(0, (i < 300) ? 20 : 47)];
			endcase
			send_evt(f, k, ($urandom_range(0, 3) == 0) ? rnd64() : 64'($urandom_range(0, 999)),
				5'($urandom_range(0, 31)));
			if (i == 700) wait_drained();
		end
		wait_drained();
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
